/* hw/rtl/tksd_pkg.sv */
// Shared constants, types and key lookup functions for the terminal key decoder.
`default_nettype none

package tksd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 5;
  localparam int unsigned PhaseW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KindW-1:0] kind_t;
  typedef logic [PhaseW-1:0] phase_t;

  // Parser phase codes
  localparam phase_t PhIdle = 2'd0;
  localparam phase_t PhEsc  = 2'd1;
  localparam phase_t PhCsi  = 2'd2;
  localparam phase_t PhSs3  = 2'd3;

  // Key kinds
  localparam kind_t KeyNone  = 5'd0;
  localparam kind_t KeyPlain = 5'd0;
  localparam kind_t KeyUp    = 5'd1;
  localparam kind_t KeyDown  = 5'd2;
  localparam kind_t KeyRight = 5'd3;
  localparam kind_t KeyLeft  = 5'd4;
  localparam kind_t KeyHome  = 5'd5;
  localparam kind_t KeyEnd   = 5'd6;
  localparam kind_t KeyDel   = 5'd7;
  localparam kind_t KeyPgUp  = 5'd8;
  localparam kind_t KeyPgDn  = 5'd9;
  localparam kind_t KeyFn1   = 5'd10;
  localparam kind_t KeyFn6   = 5'd15;
  localparam kind_t KeyFn11  = 5'd20;

  // Byte codes
  localparam byte_t ChNul   = 8'h00;
  localparam byte_t ChEsc   = 8'h1B;
  localparam byte_t ChLbr   = 8'h5B; // '['
  localparam byte_t ChO     = 8'h4F; // 'O'
  localparam byte_t ChTilde = 8'h7E; // '~'
  localparam byte_t ChSemi  = 8'h3B; // ';'
  localparam byte_t ChLt    = 8'h3C; // '<'
  localparam byte_t ChEq    = 8'h3D; // '='
  localparam byte_t ChQuest = 8'h3F; // '?'
  localparam byte_t Ch0     = 8'h30;
  localparam byte_t Ch9     = 8'h39;
  localparam byte_t ChA     = 8'h41;
  localparam byte_t ChB     = 8'h42;
  localparam byte_t ChC     = 8'h43;
  localparam byte_t ChD     = 8'h44;
  localparam byte_t ChF     = 8'h46;
  localparam byte_t ChH     = 8'h48;

  localparam byte_t NumMax = 8'd255;

  // Final letter shared by CSI and SS3; KeyNone for anything else
  function automatic kind_t letter_key(byte_t b);
    kind_t k;
    k = KeyNone;
    case (b)
      ChA:     k = KeyUp;
      ChB:     k = KeyDown;
      ChC:     k = KeyRight;
      ChD:     k = KeyLeft;
      ChH:     k = KeyHome;
      ChF:     k = KeyEnd;
      default: k = KeyNone;
    endcase
    return k;
  endfunction

  // Key selected by the number before '~'
  function automatic kind_t tilde_key(byte_t n);
    kind_t k;
    k = KeyNone;
    case (n) inside
      8'd1, 8'd7:    k = KeyHome;
      8'd2, 8'd3:    k = KeyDel;
      8'd4, 8'd8:    k = KeyEnd;
      8'd5:          k = KeyPgUp;
      8'd6:          k = KeyPgDn;
      [8'd11:8'd15]: k = KeyFn1 + kind_t'(n - 8'd11);
      [8'd17:8'd21]: k = KeyFn6 + kind_t'(n - 8'd17);
      [8'd23:8'd24]: k = KeyFn11 + kind_t'(n - 8'd23);
      default:       k = KeyNone;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tksd_if.sv */
// Valid/ready channel interfaces for input bytes and key events.
`default_nettype none

interface tksd_byte_if
  import tksd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  byte_t byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

interface tksd_key_if
  import tksd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  kind_t key_kind;
  byte_t char_value;

  modport source (output valid, output key_kind, output char_value, input ready);
  modport sink (input valid, input key_kind, input char_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/terminal_key_sequence_decoder_unit.sv */
// Top level: terminal escape sequence decoder turning raw bytes into key events.
//
//   channel | dir | payload                  | beat
//   --------+-----+--------------------------+-------------------------------
//   in_i    | in  | byte_value[7:0]          | one raw terminal byte
//   out_o   | out | key_kind[4:0], char_value | one key event (zero or one/byte)
//
// Throughput is one byte per cycle while out_o is not stalled. A byte is
// held in the input register, the parser then updates its state and loads
// the result register, from which the event is offered on out_o.
// rst_ni clears both valid flags and the parser state (idle, number 0, open).
// A stalled result holds the input register; the input side stays ready while
// the input register is empty or drains in the same cycle.
`default_nettype none

module terminal_key_sequence_decoder_unit
  import tksd_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  tksd_byte_if.sink    in_i,
  tksd_key_if.source   out_o
);

  // input register
  logic  in_vld_q, in_vld_d;
  byte_t in_byte_q;

  // parser state
  phase_t phase_q, phase_d;
  byte_t  num_q, num_d;
  logic   open_q, open_d;

  // result register
  logic  out_vld_q, out_vld_d;
  kind_t out_kind_q, out_kind_d;
  byte_t out_char_q, out_char_d;

  logic  adv;       // input register item is parsed this cycle
  logic  hit;       // parsed item gives an event
  logic  is_digit;
  logic  is_param;
  logic [11:0] num_ext;
  kind_t k;
  byte_t b;

  assign b   = in_byte_q;
  assign adv = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  assign is_digit = (b >= Ch0) && (b <= Ch9);
  assign is_param = is_digit || (b == ChSemi) || (b == ChQuest) ||
                    (b == ChLt) || (b == ChEq);
  // num*10 + digit as shifts and adds
  assign num_ext = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} +
                   {8'h00, 4'(b - Ch0)};

  always_comb begin
    phase_d    = phase_q;
    num_d      = num_q;
    open_d     = open_q;
    hit        = 1'b0;
    out_kind_d = KeyPlain;
    out_char_d = ChNul;
    k          = KeyNone;
    case (phase_q)
      PhIdle: begin
        if (b == ChEsc) begin
          phase_d = PhEsc;
        end else if (b != ChNul) begin
          hit        = 1'b1;
          out_char_d = b;
        end
      end
      PhEsc: begin
        if (b == ChLbr) begin
          phase_d = PhCsi;
          num_d   = '0;
          open_d  = 1'b1;
        end else if (b == ChO) begin
          phase_d = PhSs3;
        end else begin
          phase_d = PhIdle;
          if (b != ChNul) begin
            hit        = 1'b1;
            out_char_d = b;
          end
        end
      end
      PhCsi: begin
        if (is_param) begin
          if (open_q && is_digit) begin
            num_d = (num_ext > 12'(NumMax)) ? NumMax : num_ext[7:0];
          end else begin
            open_d = 1'b0;
          end
        end else begin
          phase_d    = PhIdle;
          k          = (b == ChTilde) ? tilde_key(num_q) : letter_key(b);
          num_d      = '0;
          open_d     = 1'b1;
          hit        = (k != KeyNone);
          out_kind_d = k;
        end
      end
      default: begin  // SS3
        phase_d    = PhIdle;
        k          = letter_key(b);
        hit        = (k != KeyNone);
        out_kind_d = k;
      end
    endcase
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = hit;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhIdle;
      num_q     <= '0;
      open_q    <= 1'b1;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        phase_q <= phase_d;
        num_q   <= num_d;
        open_q  <= open_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.byte_value;
    end
    if (adv && hit) begin
      out_kind_q <= out_kind_d;
      out_char_q <= out_char_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.key_kind   = out_kind_q;
  assign out_o.char_value = out_char_q;

endmodule

`default_nettype wire

/* tb/tb_terminal_key_sequence_decoder_unit.sv */
// Self-checking testbench for the terminal key sequence decoder top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_terminal_key_sequence_decoder_unit;
  import tksd_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned ItemsPerPhase = 210;
  localparam int unsigned NumDirected = 27;

  // One expected key event, in port order
  typedef struct packed {
    kind_t kind;
    byte_t ch;
  } key_evt_t;

  // Directed row: byte to send, and a typed-in expectation where obvious
  typedef struct {
    byte_t b;
    bit    typed;
    bit    fires;
    kind_t kind;
    byte_t ch;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  tksd_byte_if byte_if ();
  tksd_key_if  key_if ();

  terminal_key_sequence_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (key_if)
  );

  // Events still owed by the block, oldest first
  key_evt_t pending_keys[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;

  // Idling knobs, percent of cycles; hold_left is consumed by the receiver
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  // Decoder shadow state
  phase_t dec_phase;
  byte_t  dec_num;
  bit     dec_open;

  dir_row_t dir_tab [NumDirected];

  //--------------------------------------------------------------------------
  // Clock and cycle watchdog
  //--------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Decoder prediction
  //--------------------------------------------------------------------------
  function automatic kind_t final_letter_kind(byte_t b);
    case (b)
      ChA:     return KeyUp;
      ChB:     return KeyDown;
      ChC:     return KeyRight;
      ChD:     return KeyLeft;
      ChH:     return KeyHome;
      ChF:     return KeyEnd;
      default: return KeyNone;
    endcase
  endfunction

  // Number before '~'; insert (2) is folded onto delete
  function automatic kind_t tilde_code_kind(byte_t n);
    if (n == 8'd1 || n == 8'd7) return KeyHome;
    if (n == 8'd2 || n == 8'd3) return KeyDel;
    if (n == 8'd4 || n == 8'd8) return KeyEnd;
    if (n == 8'd5) return KeyPgUp;
    if (n == 8'd6) return KeyPgDn;
    if (n >= 8'd11 && n <= 8'd15) return kind_t'(KeyFn1 + (n - 8'd11));
    if (n >= 8'd17 && n <= 8'd21) return kind_t'(KeyFn1 + 5 + (n - 8'd17));
    if (n >= 8'd23 && n <= 8'd24) return kind_t'(KeyFn1 + 10 + (n - 8'd23));
    return KeyNone;
  endfunction

  function automatic bit is_digit_byte(byte_t b);
    return (b >= Ch0) && (b <= Ch9);
  endfunction

  function automatic bit is_csi_param(byte_t b);
    return is_digit_byte(b) || b == ChSemi || b == ChQuest || b == ChLt || b == ChEq;
  endfunction

  // Advances the shadow state by one byte; returns 1 when a key event is due
  function automatic bit decode_key_byte(input byte_t b, output key_evt_t evt);
    kind_t k;
    int    v;
    bit    fires;
    k = KeyNone;
    fires = 1'b0;
    evt = '0;
    case (dec_phase)
      PhIdle: begin
        if (b == ChEsc) begin
          dec_phase = PhEsc;
        end else if (b != ChNul) begin
          fires = 1'b1;
          evt.kind = KeyPlain;
          evt.ch = b;
        end
      end
      PhEsc: begin
        if (b == ChLbr) begin
          dec_phase = PhCsi;
          dec_num = '0;
          dec_open = 1'b1;
        end else if (b == ChO) begin
          dec_phase = PhSs3;
        end else begin
          // anything else after ESC but NUL, a second ESC too, is a plain byte
          dec_phase = PhIdle;
          if (b != ChNul) begin
            fires = 1'b1;
            evt.kind = KeyPlain;
            evt.ch = b;
          end
        end
      end
      PhCsi: begin
        if (is_csi_param(b)) begin
          if (dec_open && is_digit_byte(b)) begin
            v = int'(dec_num) * 10 + int'(b - Ch0);
            dec_num = (v > 255) ? NumMax : byte_t'(v);
          end else begin
            dec_open = 1'b0;
          end
        end else begin
          dec_phase = PhIdle;
          k = (b == ChTilde) ? tilde_code_kind(dec_num) : final_letter_kind(b);
          dec_num = '0;
          dec_open = 1'b1;
          if (k != KeyNone) begin
            fires = 1'b1;
            evt.kind = k;
          end
        end
      end
      default: begin
        dec_phase = PhIdle;
        k = final_letter_kind(b);
        if (k != KeyNone) begin
          fires = 1'b1;
          evt.kind = k;
        end
      end
    endcase
    return fires;
  endfunction

  //--------------------------------------------------------------------------
  // Byte sender: drives at the falling edge, detects the beat at the rising
  // edge, then runs the prediction for the accepted byte.
  //--------------------------------------------------------------------------
  task automatic send_byte(input byte_t b, input bit typed = 1'b0,
                           input bit fires = 1'b0, input kind_t kind = KeyNone,
                           input byte_t ch = '0);
    key_evt_t evt;
    bit       due;
    // random gaps; valid gets one assignment per falling edge
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      byte_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_if.valid <= 1'b1;
    byte_if.byte_value <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    due = decode_key_byte(b, evt);
    if (typed) begin
      if (fires) pending_keys.push_back('{kind: kind, ch: ch});
    end else if (due) begin
      pending_keys.push_back(evt);
    end
  endtask

  task automatic push_decimal(inout byte_t seq[$], input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) seq.push_back(byte_t'(s[i]));
  endtask

  // One random chunk: mostly well-formed sequences, some noise
  task automatic send_random_chunk();
    byte_t       seq[$];
    byte_t       letters[6];
    byte_t       prefixes[4];
    int unsigned codes[26];
    int unsigned r;
    int unsigned sel;
    letters = '{ChA, ChB, ChC, ChD, ChH, ChF};
    prefixes = '{ChQuest, ChLt, ChEq, ChSemi};
    codes = '{1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 13, 14, 15, 17, 18, 19, 20, 21,
              23, 24, 0, 9, 10, 16, 22, 25};
    r = $urandom_range(99);
    if (r < 15) begin
      seq.push_back(byte_t'($urandom_range(255)));
    end else if (r < 55) begin
      // CSI: ESC '[' [prefix] [number] [prefix digits] final
      seq.push_back(ChEsc);
      seq.push_back(ChLbr);
      if ($urandom_range(99) < 15) seq.push_back(prefixes[$urandom_range(3)]);
      sel = $urandom_range(9);
      if (sel < 6) push_decimal(seq, codes[$urandom_range(25)]);
      else if (sel < 8) push_decimal(seq, $urandom_range(999));
      else if (sel == 8) push_decimal(seq, $urandom_range(99999, 1000));
      if ($urandom_range(99) < 25) begin
        seq.push_back(prefixes[$urandom_range(3)]);
        push_decimal(seq, $urandom_range(30));
      end
      sel = $urandom_range(99);
      if (sel < 50) seq.push_back(ChTilde);
      else if (sel < 85) seq.push_back(letters[$urandom_range(5)]);
      else seq.push_back(byte_t'($urandom_range(255)));
    end else if (r < 75) begin
      seq.push_back(ChEsc);
      seq.push_back(ChO);
      if ($urandom_range(99) < 80) seq.push_back(letters[$urandom_range(5)]);
      else seq.push_back(byte_t'($urandom_range(255)));
    end else if (r < 85) begin
      seq.push_back(ChEsc);
      seq.push_back(byte_t'($urandom_range(255)));
    end else begin
      // noise, leaning on the bytes that open or break sequences
      repeat ($urandom_range(4, 1)) begin
        sel = $urandom_range(5);
        if (sel == 0) seq.push_back(ChEsc);
        else if (sel == 1) seq.push_back(ChLbr);
        else if (sel == 2) seq.push_back(ChNul);
        else seq.push_back(byte_t'($urandom_range(255)));
      end
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Sender goes quiet first so the last byte is not offered again
  task automatic wait_drained();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
  endtask

  //--------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted down here
  //--------------------------------------------------------------------------
  initial begin
    key_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        key_if.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        key_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Event checker: compares each beat with the oldest expectation
  //--------------------------------------------------------------------------
  always @(posedge clk_i) begin
    key_evt_t exp_evt;
    if (rst_ni && key_if.valid && key_if.ready) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected key event: key_kind %0d, char_value %0d",
               key_if.key_kind, key_if.char_value);
        fail_cnt++;
      end else begin
        exp_evt = pending_keys.pop_front();
        if (key_if.key_kind !== exp_evt.kind) begin
          $error("key_kind: expected %0d, actual %0d", exp_evt.kind, key_if.key_kind);
          fail_cnt++;
        end
        if (key_if.char_value !== exp_evt.ch) begin
          $error("char_value: expected %0d, actual %0d", exp_evt.ch, key_if.char_value);
          fail_cnt++;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin
    int unsigned target;
    fail_cnt = 0;
    cycle_cnt = 0;
    bytes_sent = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    dec_phase = PhIdle;
    dec_num = '0;
    dec_open = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.byte_value = '0;
    rst_ni = 1'b0;

    // Directed rows: NUL and 0xFF idle, double ESC, CSI and SS3 letters,
    // tilde F12, saturated number, NUL after ESC, number closed by ';'
    dir_tab = '{
      '{ChNul,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{8'hFF,                 1'b1, 1'b1, KeyPlain, 8'hFF},
      '{ChEsc,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChEsc,                 1'b1, 1'b1, KeyPlain, ChEsc},
      '{ChEsc,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChLbr,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChA,                   1'b1, 1'b1, KeyUp,    8'h00},
      '{ChEsc,                 1'b0, 1'b0, KeyNone,  8'h00},
      '{ChO,                   1'b0, 1'b0, KeyNone,  8'h00},
      '{ChF,                   1'b0, 1'b0, KeyNone,  8'h00},
      '{ChEsc,                 1'b0, 1'b0, KeyNone,  8'h00},
      '{ChLbr,                 1'b0, 1'b0, KeyNone,  8'h00},
      '{byte_t'(Ch0 + 8'd2),   1'b0, 1'b0, KeyNone,  8'h00},
      '{byte_t'(Ch0 + 8'd4),   1'b0, 1'b0, KeyNone,  8'h00},
      '{ChTilde,               1'b0, 1'b0, KeyNone,  8'h00},
      '{ChEsc,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChLbr,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{byte_t'(Ch0 + 8'd3),   1'b1, 1'b0, KeyNone,  8'h00},
      '{Ch0,                   1'b1, 1'b0, KeyNone,  8'h00},
      '{Ch0,                   1'b1, 1'b0, KeyNone,  8'h00},
      '{ChTilde,               1'b1, 1'b0, KeyNone,  8'h00},
      '{ChEsc,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChNul,                 1'b1, 1'b0, KeyNone,  8'h00},
      '{ChEsc,                 1'b0, 1'b0, KeyNone,  8'h00},
      '{ChLbr,                 1'b0, 1'b0, KeyNone,  8'h00},
      '{ChSemi,                1'b0, 1'b0, KeyNone,  8'h00},
      '{ChTilde,               1'b0, 1'b0, KeyNone,  8'h00}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].fires,
                dir_tab[i].kind, dir_tab[i].ch);
    wait_drained();

    // Phase 0: no idling; a long receiver hold-off backs the block up
    // while the sender keeps offering bytes
    hold_left = HoldCycles;
    target = bytes_sent + ItemsPerPhase;
    while (bytes_sent < target) send_random_chunk();
    // sender pauses until the block has handed over everything
    wait_drained();

    // Phase 1: sender idles most cycles
    send_idle_pct = 83;
    recv_stall_pct = 0;
    target = bytes_sent + ItemsPerPhase;
    while (bytes_sent < target) send_random_chunk();
    wait_drained();

    // Phase 2: receiver stalls most cycles
    send_idle_pct = 0;
    recv_stall_pct = 83;
    target = bytes_sent + ItemsPerPhase;
    while (bytes_sent < target) send_random_chunk();
    wait_drained();

    // Phase 3: both sides idle now and then
    send_idle_pct = 32;
    recv_stall_pct = 32;
    target = bytes_sent + ItemsPerPhase;
    while (bytes_sent < target) send_random_chunk();

    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* terminal_key_sequence_decoder_unit.f */
hw/rtl/tksd_pkg.sv
hw/rtl/tksd_if.sv
hw/rtl/terminal_key_sequence_decoder_unit.sv
tb/tb_terminal_key_sequence_decoder_unit.sv
